// ===== hdl/llpl_pkg.sv =====
// Shared types, constants and helpers for the least-loaded placement ledger.
// No dependencies; every other file of the block refers to it by scoped names.
package llpl_pkg;

  localparam int MAX_CAND = 16;
  localparam int GRANTS   = 8;
  localparam int CAND_W   = $clog2(MAX_CAND);
  localparam int GRANT_W  = $clog2(GRANTS);
  localparam int CNT_W    = GRANT_W + 1;

  localparam logic [31:0] INVALID_RANK   = 32'hFFFF_FFFF;
  localparam logic [15:0] STALE_RESET    = 16'd90;
  localparam logic [15:0] LIFETIME_RESET = 16'd15;

  localparam logic [1:0] CFG_STALE    = 2'd0;
  localparam logic [1:0] CFG_LIFETIME = 2'd1;

  typedef enum logic [1:0] {
    OP_REGISTER, OP_PLACE, OP_RANK_DOWN, OP_TICK
  } op_t;

  typedef enum logic [1:0] {
    STS_OK, STS_INVALID, STS_NO_CAND, STS_FULL
  } status_t;

  typedef enum logic [2:0] {
    CMD_NONE, CMD_PLACE, CMD_RETIRE, CMD_WRITE, CMD_DROP, CMD_GRANT
  } cmd_kind_t;

  typedef enum logic [2:0] {
    PH_IDLE, PH_EXPIRE, PH_SUM, PH_DROP, PH_RETIRE, PH_LOAD, PH_ELIG
  } phase_t;

  typedef enum logic [2:0] {
    CS_IDLE, CS_DISPATCH, CS_WAIT, CS_CHAIN, CS_GRANT, CS_WRITE, CS_DONE
  } ctrl_state_t;

  // Command and operands broadcast to every cell.
  typedef struct packed {
    cmd_kind_t   kind;
    logic        clear;
    logic [31:0] rank;
    logic [15:0] port;
    logic [31:0] addr;
    logic [63:0] host;
    logic [63:0] dev;
    logic [63:0] size;
    logic        media;
    logic [63:0] window;
    logic [31:0] now;
    logic [15:0] stale;
    logic [15:0] lifetime;
  } cmd_t;

  // What each cell reports back to the controller.
  typedef struct packed {
    logic        valid;
    logic        match;
    logic        busy;
    logic [31:0] rank;
    logic [15:0] port;
    logic [31:0] addr;
  } cell_stat_t;

  // Running best candidate handed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [63:0]       load;
    logic [31:0]       rank;
    logic [CAND_W-1:0] idx;
    logic [CAND_W-1:0] pos;
  } token_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

endpackage

// ===== hdl/llpl_cell.sv =====
// One ledger slot: node record, its ordered in-flight grant list and one link
// of the best-candidate chain. Depends on llpl_pkg.
module llpl_cell (
  input  logic                clk,
  input  logic                rst,
  input  llpl_pkg::cmd_t      cmd,
  input  logic                sel,
  input  llpl_pkg::token_t    tok_in,
  output llpl_pkg::token_t    tok_out,
  output llpl_pkg::cell_stat_t stat
);

  logic                         valid;
  logic [31:0]                  rank;
  logic [15:0]                  port;
  logic [31:0]                  addr;
  logic [63:0]                  host_bytes;
  logic [63:0]                  dev_bytes;
  logic [31:0]                  last_seen;
  logic [63:0]                  g_bytes [llpl_pkg::GRANTS];
  logic                         g_dev   [llpl_pkg::GRANTS];
  logic [31:0]                  g_time  [llpl_pkg::GRANTS];
  logic [llpl_pkg::CNT_W-1:0]   count;
  llpl_pkg::phase_t             phase, phase_next;
  logic [llpl_pkg::GRANT_W-1:0] idx;
  logic [llpl_pkg::CNT_W-1:0]   wr;
  logic [63:0]                  sum_h, sum_d, drop_h, drop_d, gone_h, gone_d, load;
  logic                         eligible;
  llpl_pkg::token_t             tok_q;

  logic        match, stale, live, expired, rem_h, rem_d, keep, last, win_fail, place_go;
  logic [63:0] e_bytes, committed, growth_h, growth_d;
  logic        e_dev;
  logic [31:0] e_time;

  // Per-cycle decisions of the grant walk and the placement checks.
  always_comb begin
    match     = valid && (rank == cmd.rank);
    stale     = (cmd.now - last_seen) > {16'd0, cmd.stale};
    place_go  = (cmd.kind == llpl_pkg::CMD_PLACE) && valid && !stale && (rank != cmd.rank);
    live      = {1'b0, idx} < count;
    e_bytes   = g_bytes[idx];
    e_dev     = g_dev[idx];
    e_time    = g_time[idx];
    expired   = (cmd.now - e_time) > {16'd0, cmd.lifetime};
    rem_h     = !e_dev && (gone_h < drop_h);
    rem_d     = e_dev && (gone_d < drop_d);
    last      = idx == llpl_pkg::GRANT_W'(llpl_pkg::GRANTS - 1);
    committed = cmd.media ? dev_bytes : host_bytes;
    growth_h  = (cmd.host > host_bytes) ? cmd.host - host_bytes : 64'd0;
    growth_d  = (cmd.dev > dev_bytes) ? cmd.dev - dev_bytes : 64'd0;
    win_fail  = (cmd.window != 64'd0) && ((load > cmd.window) || (cmd.size > cmd.window - load));
    unique case (phase)
      llpl_pkg::PH_EXPIRE: keep = live && !expired;
      llpl_pkg::PH_RETIRE: keep = live && !rem_h && !rem_d;
      default:             keep = 1'b0;
    endcase
  end

  // Next phase of the cell sequencer.
  always_comb begin
    phase_next = phase;
    unique case (phase)
      llpl_pkg::PH_IDLE: begin
        if (place_go) phase_next = llpl_pkg::PH_EXPIRE;
        else if (cmd.kind == llpl_pkg::CMD_RETIRE && sel) phase_next = llpl_pkg::PH_SUM;
      end
      llpl_pkg::PH_EXPIRE: if (last) phase_next = llpl_pkg::PH_LOAD;
      llpl_pkg::PH_SUM:    if (last) phase_next = llpl_pkg::PH_DROP;
      llpl_pkg::PH_DROP:   phase_next = llpl_pkg::PH_RETIRE;
      llpl_pkg::PH_RETIRE: if (last) phase_next = llpl_pkg::PH_IDLE;
      llpl_pkg::PH_LOAD:   phase_next = llpl_pkg::PH_ELIG;
      llpl_pkg::PH_ELIG:   phase_next = llpl_pkg::PH_IDLE;
      default:             phase_next = llpl_pkg::PH_IDLE;
    endcase
  end

  // Status seen by the controller.
  always_comb begin
    stat.valid = valid;
    stat.match = match;
    stat.busy  = phase != llpl_pkg::PH_IDLE;
    stat.rank  = rank;
    stat.port  = port;
    stat.addr  = addr;
    tok_out    = tok_q;
  end

  // Slot record, grant list and walk datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      count    <= '0;
      phase    <= llpl_pkg::PH_IDLE;
      eligible <= 1'b0;
    end else begin
      phase <= phase_next;
      unique case (cmd.kind)
        llpl_pkg::CMD_PLACE: begin
          eligible <= 1'b0;
          if (valid && stale) valid <= 1'b0;
        end
        llpl_pkg::CMD_DROP: if (match) valid <= 1'b0;
        llpl_pkg::CMD_WRITE: if (sel) begin
          valid      <= 1'b1;
          rank       <= cmd.rank;
          port       <= cmd.port;
          addr       <= cmd.addr;
          host_bytes <= cmd.host;
          dev_bytes  <= cmd.dev;
          last_seen  <= cmd.now;
          if (cmd.clear) count <= '0;
        end
        llpl_pkg::CMD_GRANT: if (sel) begin
          if (count < llpl_pkg::CNT_W'(llpl_pkg::GRANTS)) begin
            g_bytes[count[llpl_pkg::GRANT_W-1:0]] <= cmd.size;
            g_dev[count[llpl_pkg::GRANT_W-1:0]]   <= cmd.media;
            g_time[count[llpl_pkg::GRANT_W-1:0]]  <= cmd.now;
            count <= count + 1'b1;
          end else begin
            // Full list: the oldest grant drops out of the front.
            for (int k = 0; k < llpl_pkg::GRANTS - 1; k++) begin
              g_bytes[k] <= g_bytes[k+1];
              g_dev[k]   <= g_dev[k+1];
              g_time[k]  <= g_time[k+1];
            end
            g_bytes[llpl_pkg::GRANTS-1] <= cmd.size;
            g_dev[llpl_pkg::GRANTS-1]   <= cmd.media;
            g_time[llpl_pkg::GRANTS-1]  <= cmd.now;
          end
        end
        default: ;
      endcase

      unique case (phase)
        llpl_pkg::PH_IDLE: begin
          idx   <= '0;
          wr    <= '0;
          sum_h <= '0;
          sum_d <= '0;
        end
        llpl_pkg::PH_EXPIRE: begin
          // Drop expired grants, close the gaps and total the asked media.
          if (keep) begin
            g_bytes[wr[llpl_pkg::GRANT_W-1:0]] <= e_bytes;
            g_dev[wr[llpl_pkg::GRANT_W-1:0]]   <= e_dev;
            g_time[wr[llpl_pkg::GRANT_W-1:0]]  <= e_time;
            wr <= wr + 1'b1;
            if (e_dev == cmd.media) sum_h <= llpl_pkg::sat_add(sum_h, e_bytes);
          end
          if (last) count <= wr + llpl_pkg::CNT_W'(keep);
          idx <= idx + 1'b1;
        end
        llpl_pkg::PH_SUM: begin
          if (live) begin
            if (e_dev) sum_d <= llpl_pkg::sat_add(sum_d, e_bytes);
            else       sum_h <= llpl_pkg::sat_add(sum_h, e_bytes);
          end
          idx <= idx + 1'b1;
        end
        llpl_pkg::PH_DROP: begin
          drop_h <= (growth_h < sum_h) ? growth_h : sum_h;
          drop_d <= (growth_d < sum_d) ? growth_d : sum_d;
          gone_h <= '0;
          gone_d <= '0;
          idx    <= '0;
          wr     <= '0;
        end
        llpl_pkg::PH_RETIRE: begin
          // Retire the oldest grants of each media up to the reported growth.
          if (live && rem_h) gone_h <= llpl_pkg::sat_add(gone_h, e_bytes);
          if (live && rem_d) gone_d <= llpl_pkg::sat_add(gone_d, e_bytes);
          if (keep) begin
            g_bytes[wr[llpl_pkg::GRANT_W-1:0]] <= e_bytes;
            g_dev[wr[llpl_pkg::GRANT_W-1:0]]   <= e_dev;
            g_time[wr[llpl_pkg::GRANT_W-1:0]]  <= e_time;
            wr <= wr + 1'b1;
          end
          if (last) count <= wr + llpl_pkg::CNT_W'(keep);
          idx <= idx + 1'b1;
        end
        llpl_pkg::PH_LOAD: load <= llpl_pkg::sat_add(committed, sum_h);
        llpl_pkg::PH_ELIG: eligible <= !win_fail;
        default: ;
      endcase
    end
  end

  // Chain link: take over the running best when this slot beats it.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q.valid <= 1'b0;
    end else begin
      tok_q.valid <= tok_in.valid;
      tok_q.pos   <= tok_in.pos + 1'b1;
      if (tok_in.valid && eligible && (!tok_in.found || load < tok_in.load ||
          (load == tok_in.load && rank < tok_in.rank))) begin
        tok_q.found <= 1'b1;
        tok_q.load  <= load;
        tok_q.rank  <= rank;
        tok_q.idx   <= tok_in.pos;
      end else begin
        tok_q.found <= tok_in.found;
        tok_q.load  <= tok_in.load;
        tok_q.rank  <= tok_in.rank;
        tok_q.idx   <= tok_in.idx;
      end
    end
  end

endmodule

// ===== hdl/least_loaded_placement_ledger.sv =====
// Least-loaded placement ledger top level: controller, configuration and a row of slot cells.
// Tick, rank down and rejected items go from dispatch to done; a new-node register adds a
// write step; a known-node register runs an 8-step sum walk, a drop step and an 8-step retire
// walk. A placement runs an 8-step expiry walk, load and window steps, 16-cell candidate chain
// and grant step. One item at a time: the next is accepted as the controller returns to idle,
// once the output register takes the result. Synchronous reset empties the table and grant
// lists, zeroes the time and restores limits 90 and 15. Depends on llpl_pkg, llpl_cell.
module least_loaded_placement_ledger (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [31:0] rank,
  input  logic [15:0] node_port,
  input  logic [31:0] node_address,
  input  logic [63:0] host_committed,
  input  logic [63:0] device_committed,
  input  logic [63:0] request_size,
  input  logic        device_media,
  input  logic [63:0] host_window,
  input  logic [63:0] device_window,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] chosen_rank,
  output logic [15:0] chosen_port,
  output logic [31:0] chosen_address,
  output logic [63:0] chosen_load,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int N = llpl_pkg::MAX_CAND;

  llpl_pkg::ctrl_state_t state, state_next;
  logic [15:0]  stale_limit, grant_lifetime;
  logic [31:0]  now;
  llpl_pkg::op_t op_q;
  logic [31:0]  rank_q, addr_q;
  logic [15:0]  port_q;
  logic [63:0]  host_q, dev_q, size_q, window_q;
  logic         media_q;
  logic [N-1:0] target;
  logic         clear_q;
  llpl_pkg::token_t best;
  llpl_pkg::status_t res_status;
  logic [31:0]  res_rank, res_addr;
  logic [15:0]  res_port;
  logic [63:0]  res_load;

  llpl_pkg::cmd_t       cmd;
  logic [N-1:0]         sel;
  llpl_pkg::token_t     tok [N+1];
  llpl_pkg::cell_stat_t stat [N];
  logic [N-1:0]         match_vec, free_vec;
  logic                 any_match, any_free, any_busy, bad_reg, inject, out_load;

  // Slot lookups: matching rank and first free slot.
  always_comb begin
    logic seen;
    seen     = 1'b0;
    any_busy = 1'b0;
    for (int s = 0; s < N; s++) begin
      match_vec[s] = stat[s].match;
      free_vec[s]  = !stat[s].valid && !seen;
      if (!stat[s].valid) seen = 1'b1;
      if (stat[s].busy) any_busy = 1'b1;
    end
    any_match = |match_vec;
    any_free  = seen;
    bad_reg   = (rank_q == llpl_pkg::INVALID_RANK) || (addr_q == 32'd0) || (port_q == 16'd0);
  end

  // Next state of the controller.
  always_comb begin
    state_next = state;
    unique case (state)
      llpl_pkg::CS_IDLE: if (in_valid) state_next = llpl_pkg::CS_DISPATCH;
      llpl_pkg::CS_DISPATCH: begin
        unique case (op_q)
          llpl_pkg::OP_REGISTER: begin
            if (bad_reg) state_next = llpl_pkg::CS_DONE;
            else if (any_match) state_next = llpl_pkg::CS_WAIT;
            else if (any_free) state_next = llpl_pkg::CS_WRITE;
            else state_next = llpl_pkg::CS_DONE;
          end
          llpl_pkg::OP_PLACE:
            state_next = (size_q == 64'd0) ? llpl_pkg::CS_DONE : llpl_pkg::CS_WAIT;
          default: state_next = llpl_pkg::CS_DONE;
        endcase
      end
      llpl_pkg::CS_WAIT: if (!any_busy) begin
        state_next = (op_q == llpl_pkg::OP_REGISTER) ? llpl_pkg::CS_WRITE : llpl_pkg::CS_CHAIN;
      end
      llpl_pkg::CS_CHAIN: if (tok[N].valid) state_next = llpl_pkg::CS_GRANT;
      llpl_pkg::CS_GRANT: state_next = llpl_pkg::CS_DONE;
      llpl_pkg::CS_WRITE: state_next = llpl_pkg::CS_DONE;
      llpl_pkg::CS_DONE:  if (out_load) state_next = llpl_pkg::CS_IDLE;
      default: state_next = llpl_pkg::CS_IDLE;
    endcase
  end

  // Controller outputs: the command broadcast, slot selects and chain injection.
  always_comb begin
    in_ready     = state == llpl_pkg::CS_IDLE;
    out_load     = (state == llpl_pkg::CS_DONE) && (!out_valid || out_ready);
    inject       = (state == llpl_pkg::CS_WAIT) && !any_busy && (op_q == llpl_pkg::OP_PLACE);
    cmd.kind     = llpl_pkg::CMD_NONE;
    cmd.clear    = clear_q;
    cmd.rank     = rank_q;
    cmd.port     = port_q;
    cmd.addr     = addr_q;
    cmd.host     = host_q;
    cmd.dev      = dev_q;
    cmd.size     = size_q;
    cmd.media    = media_q;
    cmd.window   = window_q;
    cmd.now      = now;
    cmd.stale    = stale_limit;
    cmd.lifetime = grant_lifetime;
    sel          = '0;
    unique case (state)
      llpl_pkg::CS_DISPATCH: begin
        sel = match_vec;
        if (op_q == llpl_pkg::OP_PLACE && size_q != 64'd0) cmd.kind = llpl_pkg::CMD_PLACE;
        else if (op_q == llpl_pkg::OP_RANK_DOWN) cmd.kind = llpl_pkg::CMD_DROP;
        else if (op_q == llpl_pkg::OP_REGISTER && !bad_reg && any_match)
          cmd.kind = llpl_pkg::CMD_RETIRE;
      end
      llpl_pkg::CS_WRITE: begin
        sel      = target;
        cmd.kind = llpl_pkg::CMD_WRITE;
      end
      llpl_pkg::CS_GRANT: begin
        sel[best.idx] = 1'b1;
        if (best.found) cmd.kind = llpl_pkg::CMD_GRANT;
      end
      default: ;
    endcase
    tok[0]       = '0;
    tok[0].valid = inject;
  end

  // Row of slot cells, linked by the best-candidate chain.
  for (genvar s = 0; s < N; s++) begin : g_cell
    llpl_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .sel     (sel[s]),
      .tok_in  (tok[s]),
      .tok_out (tok[s+1]),
      .stat    (stat[s])
    );
  end

  assign cfg_ready = 1'b1;

  // Control registers: state, time, configuration and result hand-off.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= llpl_pkg::CS_IDLE;
      now            <= '0;
      stale_limit    <= llpl_pkg::STALE_RESET;
      grant_lifetime <= llpl_pkg::LIFETIME_RESET;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        unique case (cfg_index)
          llpl_pkg::CFG_STALE:    stale_limit    <= cfg_data;
          llpl_pkg::CFG_LIFETIME: grant_lifetime <= cfg_data;
          default: ;
        endcase
      end
      if (state == llpl_pkg::CS_DISPATCH && op_q == llpl_pkg::OP_TICK) now <= now + 32'd1;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Item operands, working results and the output register.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q     <= llpl_pkg::op_t'(op);
      rank_q   <= rank;
      port_q   <= node_port;
      addr_q   <= node_address;
      host_q   <= host_committed;
      dev_q    <= device_committed;
      size_q   <= request_size;
      media_q  <= device_media;
      window_q <= device_media ? device_window : host_window;
    end
    unique case (state)
      llpl_pkg::CS_DISPATCH: begin
        target     <= any_match ? match_vec : free_vec;
        clear_q    <= !any_match;
        res_rank   <= '0;
        res_port   <= '0;
        res_addr   <= '0;
        res_load   <= '0;
        res_status <= llpl_pkg::STS_OK;
        if (op_q == llpl_pkg::OP_REGISTER) begin
          if (bad_reg) res_status <= llpl_pkg::STS_INVALID;
          else if (!any_match && !any_free) res_status <= llpl_pkg::STS_FULL;
        end else if (op_q == llpl_pkg::OP_PLACE && size_q == 64'd0) begin
          res_status <= llpl_pkg::STS_INVALID;
        end
      end
      llpl_pkg::CS_CHAIN: if (tok[N].valid) best <= tok[N];
      llpl_pkg::CS_GRANT: begin
        if (best.found) begin
          res_rank <= best.rank;
          res_port <= stat[best.idx].port;
          res_addr <= stat[best.idx].addr;
          res_load <= best.load;
        end else begin
          res_status <= llpl_pkg::STS_NO_CAND;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      status         <= res_status;
      chosen_rank    <= res_rank;
      chosen_port    <= res_port;
      chosen_address <= res_addr;
      chosen_load    <= res_load;
    end
  end

  // At most one slot holds the rank of the current item.
  a_rank_unique: assert property (@(posedge clk) disable iff (rst) $onehot0(match_vec))
    else $error("two slots hold the same rank");

  // No cell is still walking its grants once the controller is idle.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == llpl_pkg::CS_IDLE) |-> !any_busy)
    else $error("cell busy while controller idle");

  // An accepted item is dispatched in the next cycle.
  a_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == llpl_pkg::CS_DISPATCH))
    else $error("accepted item not dispatched");

  // A chain token comes out only while the controller is in the chain state.
  a_token: assert property (@(posedge clk) disable iff (rst)
    tok[N].valid |-> (state == llpl_pkg::CS_CHAIN))
    else $error("stray chain token");

endmodule
